### sv/ssgd_pkg.sv
// ----------------------------------------------------------------------------
// ssgd_pkg
// Shared widths, types and register codes for the segmented 7-point cubic
// Savitzky-Golay first-derivative filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssgd_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_WIDTH     = 18;
    localparam int WIN_LEN        = 7;
    localparam int FILL_W         = 3;
    localparam int CFG_IDX_W      = 2;

    localparam int DIFF_W  = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = COEF_WIDTH + DIFF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DERIV_W = SAMPLE_WIDTH + 1;
    localparam int Q_W     = SUM_W - COEF_FRAC_BITS;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_val_t;
    typedef logic signed [DIFF_W-1:0]       diff_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [SUM_W-1:0]        sum_t;
    typedef logic signed [Q_W-1:0]          quot_t;
    typedef logic signed [DERIV_W-1:0]      deriv_t;
    typedef logic [FILL_W-1:0]              fill_t;
    typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t REG_COEF_NEAR = cfg_idx_t'(0);
    localparam cfg_idx_t REG_COEF_MID  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_COEF_FAR  = cfg_idx_t'(2);

    localparam coef_val_t COEF_NEAR_RST = coef_val_t'(15084);
    localparam coef_val_t COEF_MID_RST  = coef_val_t'(17424);
    localparam coef_val_t COEF_FAR_RST  = coef_val_t'(-5721);

    localparam fill_t FILL_FULL = fill_t'(WIN_LEN);

    localparam sum_t  ROUND_HALF = sum_t'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam quot_t Q_MAX = quot_t'((64'sd1 <<< (DERIV_W - 1)) - 64'sd1);
    localparam quot_t Q_MIN = quot_t'(-(64'sd1 <<< (DERIV_W - 1)));

    typedef struct packed {
        coef_val_t near_c;
        coef_val_t mid_c;
        coef_val_t far_c;
    } coef_t;

    typedef struct packed {
        diff_t   d_near;
        diff_t   d_mid;
        diff_t   d_far;
        sample_t center;
    } win_data_t;

endpackage

`default_nettype wire

### sv/ssgd_window.sv
// ----------------------------------------------------------------------------
// ssgd_window
// Seven-sample window with segment fill count; registers the symmetric
// differences and the center sample of every full window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssgd_window (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ssgd_pkg::sample_t   s_sample,
    input  wire logic                s_gap,
    output logic                     win_valid,
    input  wire logic                win_ready,
    output ssgd_pkg::win_data_t      win_data
);

    ssgd_pkg::sample_t   win_reg [ssgd_pkg::WIN_LEN];
    ssgd_pkg::fill_t     fill_reg;
    ssgd_pkg::fill_t     fill_next;
    logic                valid_reg;
    ssgd_pkg::win_data_t data_reg;
    ssgd_pkg::win_data_t data_next;
    logic                accept;
    logic                full;

    assign s_ready   = !valid_reg || win_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (fill_reg == ssgd_pkg::FILL_FULL);
    assign win_valid = valid_reg;
    assign win_data  = data_reg;

    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            if (s_gap) begin
                fill_next = '0;
            end else if (!full) begin
                fill_next = fill_reg + ssgd_pkg::fill_t'(1);
            end
        end
    end

    // differences taken from the window as it stands before the shift
    always_comb begin
        data_next.d_near = ssgd_pkg::DIFF_W'(win_reg[4]) - ssgd_pkg::DIFF_W'(win_reg[2]);
        data_next.d_mid  = ssgd_pkg::DIFF_W'(win_reg[5]) - ssgd_pkg::DIFF_W'(win_reg[1]);
        data_next.d_far  = ssgd_pkg::DIFF_W'(win_reg[6]) - ssgd_pkg::DIFF_W'(win_reg[0]);
        data_next.center = win_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (s_ready) begin
                valid_reg <= accept && !s_gap && full;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_gap) begin
            for (int i = 0; i < ssgd_pkg::WIN_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[ssgd_pkg::WIN_LEN-1] <= s_sample;
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### sv/ssgd_calc.sv
// ----------------------------------------------------------------------------
// ssgd_calc
// Weighted sum of the symmetric differences: product stage, then sum,
// round half up and saturate into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssgd_calc (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ssgd_pkg::coef_t     coef,
    input  wire logic                win_valid,
    output logic                     win_ready,
    input  wire ssgd_pkg::win_data_t win_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ssgd_pkg::sample_t        m_center_value,
    output ssgd_pkg::deriv_t         m_derivative
);

    logic              prod_valid_reg;
    ssgd_pkg::prod_t   p_near_reg;
    ssgd_pkg::prod_t   p_mid_reg;
    ssgd_pkg::prod_t   p_far_reg;
    ssgd_pkg::sample_t center_reg;

    logic              out_valid_reg;
    ssgd_pkg::sample_t out_center_reg;
    ssgd_pkg::deriv_t  out_deriv_reg;
    ssgd_pkg::deriv_t  deriv_next;

    ssgd_pkg::sum_t    sum;
    ssgd_pkg::quot_t   quot;
    logic              out_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign win_ready = !prod_valid_reg || out_ready;

    always_comb begin
        sum = ssgd_pkg::SUM_W'(p_near_reg) + ssgd_pkg::SUM_W'(p_mid_reg)
            + ssgd_pkg::SUM_W'(p_far_reg) + ssgd_pkg::ROUND_HALF;
        // arithmetic shift: floor division by the coefficient scale
        quot = sum[ssgd_pkg::SUM_W-1:ssgd_pkg::COEF_FRAC_BITS];
        if (quot > ssgd_pkg::Q_MAX) begin
            deriv_next = ssgd_pkg::Q_MAX[ssgd_pkg::DERIV_W-1:0];
        end else if (quot < ssgd_pkg::Q_MIN) begin
            deriv_next = ssgd_pkg::Q_MIN[ssgd_pkg::DERIV_W-1:0];
        end else begin
            deriv_next = quot[ssgd_pkg::DERIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (win_ready) begin
                prod_valid_reg <= win_valid;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (win_ready && win_valid) begin
            p_near_reg <= coef.near_c * win_data.d_near;
            p_mid_reg  <= coef.mid_c * win_data.d_mid;
            p_far_reg  <= coef.far_c * win_data.d_far;
            center_reg <= win_data.center;
        end
        if (out_ready && prod_valid_reg) begin
            out_center_reg <= center_reg;
            out_deriv_reg  <= deriv_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_center_value = out_center_reg;
    assign m_derivative   = out_deriv_reg;

endmodule

`default_nettype wire

### sv/segmented_savgol_derivative.sv
// Path: a result reaches m_* through the window register, loaded at the edge that
//   accepts its sample, then through the product and output registers.
// Throughput: one item per cycle; each stage holds its item only while the
//   next one is full, so a waiting result stops new samples once all three fill.
// Reset (aresetn, synchronous, active low): segment fill count and all valid
//   flags clear, coefficients return to their defaults.
// ----------------------------------------------------------------------------
// segmented_savgol_derivative
// Segmented 7-point cubic Savitzky-Golay first-derivative filter with a gap
// input that restarts the segment and three programmable weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segmented_savgol_derivative (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire ssgd_pkg::cfg_idx_t    cfg_index,
    input  wire ssgd_pkg::coef_val_t   cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ssgd_pkg::sample_t     s_sample,
    input  wire logic                  s_gap,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ssgd_pkg::sample_t          m_center_value,
    output ssgd_pkg::deriv_t           m_derivative
);

    ssgd_pkg::coef_t     coef_reg;
    logic                win_valid;
    logic                win_ready;
    ssgd_pkg::win_data_t win_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.near_c <= ssgd_pkg::COEF_NEAR_RST;
            coef_reg.mid_c  <= ssgd_pkg::COEF_MID_RST;
            coef_reg.far_c  <= ssgd_pkg::COEF_FAR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssgd_pkg::REG_COEF_NEAR: coef_reg.near_c <= cfg_wdata;
                ssgd_pkg::REG_COEF_MID:  coef_reg.mid_c  <= cfg_wdata;
                ssgd_pkg::REG_COEF_FAR:  coef_reg.far_c  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ssgd_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_gap     (s_gap),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_data  (win_data)
    );

    ssgd_calc u_calc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .coef           (coef_reg),
        .win_valid      (win_valid),
        .win_ready      (win_ready),
        .win_data       (win_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_center_value (m_center_value),
        .m_derivative   (m_derivative)
    );

endmodule

`default_nettype wire
